/* rtl/tlpc_pkg.sv */
// ----------------------------------------------------------------------------
// tlpc_pkg
// Shared types and constants of the tick ladder price converter: field
// widths, opcodes, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpc_pkg;

	localparam int PRICE_W   = 32;
	localparam int TICK_SZ_W = 24;
	localparam int TICKS_W   = 32;
	localparam int IDX_W     = 5;
	localparam int CFG_W     = 6;
	// wide enough to hold any segment count up to 64
	localparam int CNT_W     = 7;

	// divider: numerator 2*d+ts (34 bits), divisor 2*ts (25 bits)
	localparam int DIV_NW = 34;
	localparam int DIV_DW = 25;
	localparam int DIV_CW = 6;

	localparam int PROD_W = PRICE_W + TICK_SZ_W;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_P2T  = 2'd1,
		OP_T2P  = 2'd2
	} opcode_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BELOW    = 2'd1;
	localparam logic [1:0] ST_SAT      = 2'd2;
	localparam logic [1:0] ST_BAD_LOAD = 2'd3;

	typedef enum logic [1:0] {
		RD_PREV = 2'd0,
		RD_CUR  = 2'd1,
		RD_SCAN = 2'd2,
		RD_SEG  = 2'd3
	} rd_sel_t;

	typedef enum logic [2:0] {
		RES_OK_ZERO  = 3'd0,
		RES_BAD_LOAD = 3'd1,
		RES_BELOW    = 3'd2,
		RES_P2T      = 3'd3,
		RES_T2P      = 3'd4
	} res_kind_t;

	typedef struct packed {
		logic      cap_in;
		logic      mem_wr_seg;
		rd_sel_t   rd_sel;
		logic      rb_init;
		logic      rb_lat_prev;
		logic      rb_lat_cur;
		logic      div_start_rb;
		logic      rb_write;
		logic      scan_clr;
		logic      scan_step;
		logic      fetch;
		logic      div_start_cv;
		logic      mul;
		logic      res_wr;
		res_kind_t res_kind;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    load_bad;
		logic    neg;
		logic    below;
		logic    rb_last;
		logic    rb_gap_ok;
		logic    scan_last;
		logic    div_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/tlpc_div.sv */
// ----------------------------------------------------------------------------
// tlpc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_div
	import tlpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0] den,
	output logic                   busy,
	output logic [DIV_NW-1:0]      quot
);

	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] qn_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	assign trial = {rem_q, qn_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CW'(DIV_NW);
		end else if (busy) begin
			cnt_q <= cnt_q - DIV_CW'(1);
		end
	end

	// numerator shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			qn_q  <= num;
		end else if (busy) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			qn_q  <= {qn_q[DIV_NW-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = qn_q;

endmodule

`default_nettype wire

/* rtl/tlpc_datapath.sv */
// ----------------------------------------------------------------------------
// tlpc_datapath
// Segment tables, start rebuild, segment scan, divider, multiplier and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_datapath
	import tlpc_pkg::*;
#(
	parameter int MAX_SEGMENTS = 32
)(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dp_cmd_t                     cmd,
	output dp_stat_t                         stat,
	input  wire logic [1:0]                  opcode,
	input  wire logic [IDX_W-1:0]            segment_index,
	input  wire logic [PRICE_W-1:0]          segment_base_price,
	input  wire logic [TICK_SZ_W-1:0]        segment_tick_size,
	input  wire logic [PRICE_W-1:0]          price_in,
	input  wire logic signed [TICKS_W-1:0]   ticks_in,
	input  wire logic                        cfg_wr_en,
	input  wire logic [CFG_W-1:0]            cfg_wr_data,
	output logic [TICKS_W-1:0]               ticks_out,
	output logic [PRICE_W-1:0]               price_out,
	output logic [1:0]                       status
);

	localparam int AW = $clog2(MAX_SEGMENTS);

	// segment tables
	logic [PRICE_W-1:0]   base_mem [MAX_SEGMENTS];
	logic [TICK_SZ_W-1:0] tick_mem [MAX_SEGMENTS];
	logic [TICKS_W-1:0]   cum_mem  [MAX_SEGMENTS];

	logic [AW-1:0]        rd_addr;
	logic [PRICE_W-1:0]   rd_base_q;
	logic [TICK_SZ_W-1:0] rd_tick_q;
	logic [TICKS_W-1:0]   rd_cum_q;

	// captured item
	opcode_t              op_q;
	logic [IDX_W-1:0]     idx_q;
	logic [PRICE_W-1:0]   lbase_q;
	logic [TICK_SZ_W-1:0] lts_q;
	logic [PRICE_W-1:0]   price_q;
	logic [TICKS_W-1:0]   traw_q;

	logic [CFG_W-1:0]     seg_in_use_q;
	logic [CNT_W-1:0]     cfg_ext;
	logic [AW-1:0]        n_last;

	// rebuild
	logic [AW-1:0]        rb_i_q;
	logic [PRICE_W-1:0]   prev_base_q;
	logic [TICK_SZ_W-1:0] prev_tick_q;
	logic [TICKS_W-1:0]   prev_cum_q;
	logic [PRICE_W-1:0]   hi_base_q;
	logic [TICK_SZ_W-1:0] hi_tick_q;
	logic                 gap_ok;
	logic [DIV_NW:0]      rb_acc;
	logic [TICKS_W-1:0]   rb_acc_sat;

	// scan and conversion
	logic [AW-1:0]        scan_j_q;
	logic [AW-1:0]        seg_s_q;
	logic                 below_q;
	logic                 cmp_v_s1;
	logic [AW-1:0]        cmp_idx_s1;
	logic                 hit;
	logic [PRICE_W-1:0]   seg_base_q;
	logic [TICK_SZ_W-1:0] seg_tick_q;
	logic [TICKS_W-1:0]   seg_cum_q;
	logic [PRICE_W-1:0]   diff_q;
	logic [PROD_W-1:0]    prod_q;

	logic                 div_start;
	logic                 div_busy;
	logic [DIV_NW-1:0]    div_num;
	logic [DIV_DW-1:0]    div_den;
	logic [DIV_NW-1:0]    quot;

	logic [DIV_NW:0]      p2t_sum;
	logic [PROD_W:0]      t2p_sum;

	logic                 cum_we;
	logic [AW-1:0]        cum_waddr;
	logic [TICKS_W-1:0]   cum_wdata;

	logic [TICKS_W-1:0]   ticks_res_q;
	logic [PRICE_W-1:0]   price_res_q;
	logic [1:0]           status_res_q;

	// active segment count: 0 acts as 1, larger than the table acts as full
	assign cfg_ext = CNT_W'(seg_in_use_q);
	always_comb begin
		if (seg_in_use_q == '0) begin
			n_last = '0;
		end else if (cfg_ext > CNT_W'(MAX_SEGMENTS)) begin
			n_last = AW'(MAX_SEGMENTS - 1);
		end else begin
			n_last = AW'(cfg_ext - CNT_W'(1));
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_PREV: rd_addr = rb_i_q - AW'(1);
			RD_CUR:  rd_addr = rb_i_q;
			RD_SCAN: rd_addr = scan_j_q;
			RD_SEG:  rd_addr = seg_s_q;
			default: rd_addr = scan_j_q;
		endcase
	end

	assign cum_we    = cmd.mem_wr_seg | cmd.rb_write;
	assign cum_waddr = cmd.rb_write ? rb_i_q : '0;
	assign cum_wdata = cmd.rb_write ? rb_acc_sat : '0;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr_seg) begin
			base_mem[AW'(idx_q)] <= lbase_q;
			tick_mem[AW'(idx_q)] <= lts_q;
		end
		if (cum_we) begin
			cum_mem[cum_waddr] <= cum_wdata;
		end
		rd_base_q <= base_mem[rd_addr];
		rd_tick_q <= tick_mem[rd_addr];
		rd_cum_q  <= cum_mem[rd_addr];
	end

	assign gap_ok     = (hi_base_q > prev_base_q) && (prev_tick_q != '0);
	assign rb_acc     = (DIV_NW+1)'(prev_cum_q) + (gap_ok ? (DIV_NW+1)'(quot) : '0);
	assign rb_acc_sat = (|rb_acc[DIV_NW:TICKS_W]) ? '1 : rb_acc[TICKS_W-1:0];

	assign hit = (op_q == OP_T2P) ? (rd_cum_q <= traw_q) : (rd_base_q <= price_q);

	// price to ticks divides 2*d+ts by 2*ts, which rounds half up
	assign div_start = cmd.div_start_rb | cmd.div_start_cv;
	assign div_num   = cmd.div_start_cv ?
		({1'b0, diff_q, 1'b0} + DIV_NW'(seg_tick_q)) :
		DIV_NW'(hi_base_q - prev_base_q);
	assign div_den   = cmd.div_start_cv ? {seg_tick_q, 1'b0} : {1'b0, prev_tick_q};

	tlpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign p2t_sum = (DIV_NW+1)'(seg_cum_q) + (DIV_NW+1)'(quot);
	assign t2p_sum = (PROD_W+1)'(seg_base_q) + (PROD_W+1)'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_in_use_q <= CFG_W'(1);
			rb_i_q       <= '0;
			scan_j_q     <= '0;
			seg_s_q      <= '0;
			below_q      <= 1'b0;
			cmp_v_s1     <= 1'b0;
			cmp_idx_s1   <= '0;
		end else begin
			if (cfg_wr_en) begin
				seg_in_use_q <= cfg_wr_data;
			end
			if (cmd.rb_init) begin
				rb_i_q <= (idx_q == '0) ? AW'(1) : AW'(idx_q);
			end else if (cmd.rb_write) begin
				rb_i_q <= rb_i_q + AW'(1);
			end
			if (cmd.scan_clr) begin
				scan_j_q <= '0;
				seg_s_q  <= '0;
				below_q  <= 1'b0;
				cmp_v_s1 <= 1'b0;
			end else begin
				cmp_v_s1 <= cmd.scan_step;
				if (cmd.scan_step) begin
					scan_j_q   <= scan_j_q + AW'(1);
					cmp_idx_s1 <= scan_j_q;
				end
				// entry 0 decides below-range; later entries move the segment up
				if (cmp_v_s1) begin
					if (cmp_idx_s1 == '0) begin
						below_q <= !hit;
					end else if (hit) begin
						seg_s_q <= cmp_idx_s1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q    <= opcode_t'(opcode);
			idx_q   <= segment_index;
			lbase_q <= segment_base_price;
			lts_q   <= segment_tick_size;
			price_q <= price_in;
			traw_q  <= $unsigned(ticks_in);
		end
		if (cmd.rb_lat_prev) begin
			prev_base_q <= rd_base_q;
			prev_tick_q <= rd_tick_q;
			prev_cum_q  <= rd_cum_q;
		end else if (cmd.rb_write) begin
			prev_base_q <= hi_base_q;
			prev_tick_q <= hi_tick_q;
			prev_cum_q  <= rb_acc_sat;
		end
		if (cmd.rb_lat_cur) begin
			hi_base_q <= rd_base_q;
			hi_tick_q <= rd_tick_q;
		end
		if (cmd.fetch) begin
			seg_base_q <= rd_base_q;
			seg_tick_q <= rd_tick_q;
			seg_cum_q  <= rd_cum_q;
			diff_q     <= (op_q == OP_T2P) ? (traw_q - rd_cum_q) : (price_q - rd_base_q);
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(diff_q) * PROD_W'(seg_tick_q);
		end
		if (cmd.res_wr) begin
			ticks_res_q  <= '0;
			price_res_q  <= '0;
			status_res_q <= ST_OK;
			case (cmd.res_kind)
				RES_OK_ZERO:  status_res_q <= ST_OK;
				RES_BAD_LOAD: status_res_q <= ST_BAD_LOAD;
				RES_BELOW:    status_res_q <= ST_BELOW;
				RES_P2T: begin
					if (|p2t_sum[DIV_NW:TICKS_W]) begin
						ticks_res_q  <= '1;
						status_res_q <= ST_SAT;
					end else begin
						ticks_res_q <= p2t_sum[TICKS_W-1:0];
					end
				end
				RES_T2P: begin
					if (|t2p_sum[PROD_W:PRICE_W]) begin
						price_res_q  <= '1;
						status_res_q <= ST_SAT;
					end else begin
						price_res_q <= t2p_sum[PRICE_W-1:0];
					end
				end
				default: status_res_q <= ST_OK;
			endcase
		end
	end

	assign stat.op        = op_q;
	assign stat.load_bad  = (CNT_W'(idx_q) >= CNT_W'(MAX_SEGMENTS)) || (lts_q == '0);
	assign stat.neg       = traw_q[TICKS_W-1];
	assign stat.below     = below_q;
	assign stat.rb_last   = rb_i_q == AW'(MAX_SEGMENTS - 1);
	assign stat.rb_gap_ok = gap_ok;
	assign stat.scan_last = scan_j_q == n_last;
	assign stat.div_busy  = div_busy;

	assign ticks_out = ticks_res_q;
	assign price_out = price_res_q;
	assign status    = status_res_q;

endmodule

`default_nettype wire

/* rtl/tlpc_ctrl.sv */
// ----------------------------------------------------------------------------
// tlpc_ctrl
// Sequencer for loads, start rebuilds and conversions; owns the output
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_ctrl
	import tlpc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_DISP   = 18'h00002,
		S_LDWR   = 18'h00004,
		S_RBRDP  = 18'h00008,
		S_RBLATP = 18'h00010,
		S_RBCUR  = 18'h00020,
		S_RBCHK  = 18'h00040,
		S_RBDIV  = 18'h00080,
		S_RBWR   = 18'h00100,
		S_RBRD   = 18'h00200,
		S_SCAN   = 18'h00400,
		S_SCEND  = 18'h00800,
		S_SEL    = 18'h01000,
		S_FETCH  = 18'h02000,
		S_CVST   = 18'h04000,
		S_CVDIV  = 18'h08000,
		S_MUL    = 18'h10000,
		S_FIN    = 18'h20000
	} state_t;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;
	logic      out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = RD_SCAN;
		cmd.res_kind = kind_q;
		state_d      = state_q;
		kind_d       = kind_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.op)
					OP_LOAD: begin
						if (stat.load_bad) begin
							kind_d  = RES_BAD_LOAD;
							state_d = S_FIN;
						end else begin
							state_d = S_LDWR;
						end
					end
					OP_P2T: begin
						cmd.scan_clr = 1'b1;
						state_d      = S_SCAN;
					end
					OP_T2P: begin
						if (stat.neg) begin
							kind_d  = RES_BELOW;
							state_d = S_FIN;
						end else begin
							cmd.scan_clr = 1'b1;
							state_d      = S_SCAN;
						end
					end
					default: begin
						kind_d  = RES_OK_ZERO;
						state_d = S_FIN;
					end
				endcase
			end
			S_LDWR: begin
				cmd.mem_wr_seg = 1'b1;
				cmd.rb_init    = 1'b1;
				state_d        = S_RBRDP;
			end
			S_RBRDP: begin
				cmd.rd_sel = RD_PREV;
				state_d    = S_RBLATP;
			end
			S_RBLATP: begin
				cmd.rb_lat_prev = 1'b1;
				cmd.rd_sel      = RD_CUR;
				state_d         = S_RBCUR;
			end
			S_RBCUR: begin
				cmd.rb_lat_cur = 1'b1;
				state_d        = S_RBCHK;
			end
			S_RBCHK: begin
				if (stat.rb_gap_ok) begin
					cmd.div_start_rb = 1'b1;
					state_d          = S_RBDIV;
				end else begin
					state_d = S_RBWR;
				end
			end
			S_RBDIV: begin
				if (!stat.div_busy) begin
					state_d = S_RBWR;
				end
			end
			S_RBWR: begin
				cmd.rb_write = 1'b1;
				if (stat.rb_last) begin
					kind_d  = RES_OK_ZERO;
					state_d = S_FIN;
				end else begin
					state_d = S_RBRD;
				end
			end
			S_RBRD: begin
				cmd.rd_sel = RD_CUR;
				state_d    = S_RBCUR;
			end
			S_SCAN: begin
				cmd.rd_sel    = RD_SCAN;
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_SCEND;
				end
			end
			// last compare lands here
			S_SCEND: begin
				state_d = S_SEL;
			end
			S_SEL: begin
				cmd.rd_sel = RD_SEG;
				state_d    = S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				if (stat.op == OP_T2P) begin
					state_d = S_MUL;
				end else if (stat.below) begin
					kind_d  = RES_BELOW;
					state_d = S_FIN;
				end else begin
					state_d = S_CVST;
				end
			end
			S_CVST: begin
				cmd.div_start_cv = 1'b1;
				state_d          = S_CVDIV;
			end
			S_CVDIV: begin
				if (!stat.div_busy) begin
					kind_d  = RES_P2T;
					state_d = S_FIN;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				kind_d  = RES_T2P;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.res_wr = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= RES_OK_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.res_wr) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DISP))
		else $error("accepted item not dispatched");

	a_result_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_wr |=> out_valid)
		else $error("result written without valid");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_start_rb || cmd.div_start_cv) |-> !stat.div_busy)
		else $error("divider restarted while busy");

	a_rb_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rb_write |-> !stat.div_busy)
		else $error("segment start written before quotient ready");

endmodule

`default_nettype wire

/* rtl/tick_ladder_price_converter_core.sv */
// ----------------------------------------------------------------------------
// tick_ladder_price_converter_core
// Price to tick and tick to price conversion on a piecewise tick ladder.
// ----------------------------------------------------------------------------
// One item is handled at a time; a new item is taken once the previous one
// has its result in the output register, even if that result is still
// stalled. Price to ticks does one table read per active segment for the
// scan, then a pass through the serial divider. Ticks to price does the scan
// plus one multiply. A load of segment k rebuilds the segment starts from
// max(k,1) to the end of the table, with one table read per segment and,
// where the base rises over a nonzero previous tick size, one pass of the
// divider. The user must write segments_in_use only while no item is in
// progress; the block itself does not enforce it.
`default_nettype none

module tick_ladder_price_converter_core
	import tlpc_pkg::*;
#(
	parameter int MAX_SEGMENTS = 32
)(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                opcode,
	input  wire logic [IDX_W-1:0]          segment_index,
	input  wire logic [PRICE_W-1:0]        segment_base_price,
	input  wire logic [TICK_SZ_W-1:0]      segment_tick_size,
	input  wire logic [PRICE_W-1:0]        price_in,
	input  wire logic signed [TICKS_W-1:0] ticks_in,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [TICKS_W-1:0]             ticks_out,
	output logic [PRICE_W-1:0]             price_out,
	output logic [1:0]                     status,
	input  wire logic                      cfg_wr_en,
	input  wire logic [CFG_W-1:0]          cfg_wr_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tlpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	tlpc_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.opcode             (opcode),
		.segment_index      (segment_index),
		.segment_base_price (segment_base_price),
		.segment_tick_size  (segment_tick_size),
		.price_in           (price_in),
		.ticks_in           (ticks_in),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.ticks_out          (ticks_out),
		.price_out          (price_out),
		.status             (status)
	);

endmodule

`default_nettype wire

/* verif/tb_tick_ladder_price_converter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tick_ladder_price_converter_core
// Self-checking bench for the tick ladder converter. It loads ladders,
// converts prices to ticks and back, and checks every result against a
// ladder model held in the bench. Both sides idle at random.
// ----------------------------------------------------------------------------

module tb_tick_ladder_price_converter_core;
	import tlpc_pkg::*;

	localparam int          NUM_SEGS     = 32;
	localparam int          RANDOM_ITEMS = 550;
	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam logic [31:0] PRICE_MAX    = 32'hFFFF_FFFF;
	localparam logic [63:0] SAT_LIMIT    = 64'h0000_0000_FFFF_FFFF;

	typedef struct {
		logic [1:0]           op;
		logic [IDX_W-1:0]     idx;
		logic [PRICE_W-1:0]   base;
		logic [TICK_SZ_W-1:0] tick;
		logic [PRICE_W-1:0]   price;
		logic [TICKS_W-1:0]   ticks;
	} ladder_item_t;

	typedef struct {
		logic [TICKS_W-1:0] ticks;
		logic [PRICE_W-1:0] price;
		logic [1:0]         status;
	} ladder_result_t;

	logic                        clk;
	logic                        arst_n             = 1'b0;
	logic                        in_valid           = 1'b0;
	logic                        in_stall;
	logic [1:0]                  opcode             = OP_LOAD;
	logic [IDX_W-1:0]            segment_index      = '0;
	logic [PRICE_W-1:0]          segment_base_price = '0;
	logic [TICK_SZ_W-1:0]        segment_tick_size  = '0;
	logic [PRICE_W-1:0]          price_in           = '0;
	logic signed [TICKS_W-1:0]   ticks_in           = '0;
	logic                        out_valid;
	logic                        out_stall          = 1'b0;
	logic [TICKS_W-1:0]          ticks_out;
	logic [PRICE_W-1:0]          price_out;
	logic [1:0]                  status;
	logic                        cfg_wr_en          = 1'b0;
	logic [CFG_W-1:0]            cfg_wr_data        = '0;

	// ladder model
	logic [PRICE_W-1:0]   ladder_base  [NUM_SEGS];
	logic [TICK_SZ_W-1:0] ladder_tick  [NUM_SEGS];
	logic [TICKS_W-1:0]   ladder_start [NUM_SEGS];
	logic [CFG_W-1:0]     seg_count_reg;
	logic [NUM_SEGS-1:0]  seg_written;

	ladder_result_t pending_conversions [$];
	int mismatch_count = 0;
	int results_seen   = 0;
	int random_sent    = 0;
	int hold_cycles    = 0;
	bit counting       = 1'b0;
	bit no_gaps        = 1'b0;

	tick_ladder_price_converter_core DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.opcode             (opcode),
		.segment_index      (segment_index),
		.segment_base_price (segment_base_price),
		.segment_tick_size  (segment_tick_size),
		.price_in           (price_in),
		.ticks_in           (ticks_in),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.ticks_out          (ticks_out),
		.price_out          (price_out),
		.status             (status),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		#(25_000_000);
		$display("[tick_ladder_price_converter_core] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Ladder model
	// ------------------------------------------------------------------
	function automatic void rebuild_ladder_starts();
		logic [63:0] acc;
		ladder_start[0] = '0;
		for (int i = 1; i < NUM_SEGS; i++) begin
			acc = {32'd0, ladder_start[i-1]};
			if (ladder_base[i] > ladder_base[i-1] && ladder_tick[i-1] != 0)
				acc += {32'd0, ladder_base[i] - ladder_base[i-1]} / {40'd0, ladder_tick[i-1]};
			ladder_start[i] = (acc > SAT_LIMIT) ? PRICE_MAX : acc[31:0];
		end
	endfunction

	function automatic int active_segments();
		if (seg_count_reg == 0)
			return 1;
		if (seg_count_reg > NUM_SEGS)
			return NUM_SEGS;
		return int'(seg_count_reg);
	endfunction

	function automatic ladder_result_t ladder_convert(ladder_item_t it);
		ladder_result_t r;
		logic [63:0] d, ts, q, sum;
		int s, n;
		r.ticks  = '0;
		r.price  = '0;
		r.status = ST_OK;
		n = active_segments();
		s = 0;
		case (it.op)
			OP_LOAD: begin
				if (it.tick == 0) begin
					r.status = ST_BAD_LOAD;
				end else begin
					ladder_base[it.idx] = it.base;
					ladder_tick[it.idx] = it.tick;
					rebuild_ladder_starts();
				end
			end
			OP_P2T: begin
				if (it.price < ladder_base[0]) begin
					r.status = ST_BELOW;
				end else begin
					for (int i = 1; i < n; i++)
						if (ladder_base[i] <= it.price)
							s = i;
					d  = {32'd0, it.price - ladder_base[s]};
					ts = {40'd0, ladder_tick[s]};
					// nearest tick, half rounds up
					q   = (ts != 0) ? (64'd2 * d + ts) / (64'd2 * ts) : 64'd0;
					sum = {32'd0, ladder_start[s]} + q;
					if (sum > SAT_LIMIT) begin
						r.ticks  = PRICE_MAX;
						r.status = ST_SAT;
					end else begin
						r.ticks = sum[31:0];
					end
				end
			end
			OP_T2P: begin
				if (it.ticks[TICKS_W-1]) begin
					r.status = ST_BELOW;
				end else begin
					for (int i = 1; i < n; i++)
						if (ladder_start[i] <= it.ticks)
							s = i;
					d   = {32'd0, it.ticks - ladder_start[s]};
					sum = {32'd0, ladder_base[s]} + d * {40'd0, ladder_tick[s]};
					if (sum > SAT_LIMIT) begin
						r.price  = PRICE_MAX;
						r.status = ST_SAT;
					end else begin
						r.price = sum[31:0];
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int written_prefix();
		int c;
		c = 0;
		while (c < NUM_SEGS && seg_written[c])
			c++;
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Item builders
	// ------------------------------------------------------------------
	function automatic ladder_item_t noise_item(logic [1:0] op);
		ladder_item_t it;
		it.op    = op;
		it.idx   = IDX_W'($urandom_range(0, NUM_SEGS - 1));
		it.base  = $urandom;
		it.tick  = TICK_SZ_W'($urandom_range(0, 24'hFF_FFFF));
		it.price = $urandom;
		it.ticks = $urandom;
		return it;
	endfunction

	function automatic ladder_item_t load_item(int unsigned idx, logic [31:0] base,
			logic [23:0] tick);
		ladder_item_t it;
		it      = noise_item(OP_LOAD);
		it.idx  = IDX_W'(idx);
		it.base = base;
		it.tick = tick;
		return it;
	endfunction

	function automatic ladder_item_t price_item(logic [31:0] price);
		ladder_item_t it;
		it       = noise_item(OP_P2T);
		it.price = price;
		return it;
	endfunction

	function automatic ladder_item_t ticks_item(logic [31:0] ticks);
		ladder_item_t it;
		it       = noise_item(OP_T2P);
		it.ticks = ticks;
		return it;
	endfunction

	function automatic logic [23:0] random_tick();
		case ($urandom_range(0, 3))
			0:       return TICK_SZ_W'($urandom_range(1, 10));
			1:       return TICK_SZ_W'($urandom_range(1, 1000));
			2:       return TICK_SZ_W'($urandom_range(1, 100_000));
			default: return TICK_SZ_W'($urandom_range(1, 24'hFF_FFFF));
		endcase
	endfunction

	// mostly conversions aimed at segment edges, plus some noise
	function automatic ladder_item_t random_conversion(int n);
		ladder_item_t it;
		int s;
		logic [63:0] p, b, st, t, k;
		s  = $urandom_range(0, n - 1);
		b  = {32'd0, ladder_base[s]};
		t  = {40'd0, ladder_tick[s]};
		st = {32'd0, ladder_start[s]};
		k  = 64'($urandom_range(0, 20));
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7: begin
				case ($urandom_range(0, 4))
					0:       p = b;
					1:       p = b - 64'd1;
					2:       p = b + k * t + t / 64'd2;
					3:       p = b + k * t + t / 64'd2 - 64'd1;
					default: p = b + 64'($urandom_range(0, 32'(64'd20 * t)));
				endcase
				it = price_item(p[31:0]);
			end
			8, 9, 10, 11, 12, 13: begin
				case ($urandom_range(0, 4))
					0:       p = st;
					1:       p = st - 64'd1;
					2:       p = st + 64'($urandom_range(0, 100));
					3:       p = 64'($urandom & 32'h7FFF_FFFF);
					default: p = 64'h7FFF_FFFF;
				endcase
				it = ticks_item(p[31:0]);
			end
			14:      it = price_item($urandom);
			15:      it = ticks_item($urandom);
			16:      it = noise_item(OP_UNUSED);
			17:      it = load_item($urandom_range(0, NUM_SEGS - 1), $urandom, '0);
			default: it = load_item($urandom_range(0, NUM_SEGS - 1), $urandom, random_tick());
		endcase
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Driving and checking
	// ------------------------------------------------------------------
	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		// keep the log bounded if everything goes wrong
		if (mismatch_count <= 200)
			$display("%0t ns mismatch: %s", $time, msg);
	endtask

	task automatic send_item(input ladder_item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid           <= 1'b1;
		opcode             <= it.op;
		segment_index      <= it.idx;
		segment_base_price <= it.base;
		segment_tick_size  <= it.tick;
		price_in           <= it.price;
		ticks_in           <= it.ticks;
		do @(posedge clk); while (in_stall);
		pending_conversions.push_back(ladder_convert(it));
		if (it.op == OP_LOAD && it.tick != 0)
			seg_written[it.idx] = 1'b1;
		if (counting && it.op != OP_UNUSED && !(it.op == OP_LOAD && it.tick == 0))
			random_sent++;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_conversions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_segment_count(input logic [CFG_W-1:0] value);
		drain_pipeline();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		seg_count_reg  = value;
	endtask

	initial begin : result_sink
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				wait_cycles = hold_cycles;
				hold_cycles = 0;
			end else begin
				wait_cycles = no_gaps ? 0 : $urandom_range(0, 12);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		ladder_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_conversions.size() == 0) begin
				flag_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = pending_conversions.pop_front();
				if (ticks_out !== want.ticks)
					flag_mismatch($sformatf("result %0d ticks_out %h, expected %h",
						results_seen, ticks_out, want.ticks));
				if (price_out !== want.price)
					flag_mismatch($sformatf("result %0d price_out %h, expected %h",
						results_seen, price_out, want.price));
				if (status !== want.status)
					flag_mismatch($sformatf("result %0d status %0d, expected %0d",
						results_seen, status, want.status));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_load_checks();
		// zero tick size is rejected and leaves the table alone
		send_item(load_item(0, $urandom, '0));
		send_item(noise_item(OP_UNUSED));
		send_item(load_item(0, 32'd1_000_000, 24'd25));
		send_item(load_item(1, 32'd1_001_000, 24'd50));
		send_item(load_item(2, 32'd1_010_000, 24'hFF_FFFF));
		set_segment_count(3);
	endtask

	task automatic test_rounding_and_range();
		logic [31:0] prices [7] = '{32'd0, 32'd999_999, 32'd1_000_000, 32'd1_000_013,
			32'd1_001_024, 32'd1_001_025, PRICE_MAX};
		logic [31:0] tick_counts [5] = '{32'd0, 32'd40, 32'd220, 32'h7FFF_FFFF,
			32'h8000_0000};
		foreach (prices[i])
			send_item(price_item(prices[i]));
		foreach (tick_counts[i])
			send_item(ticks_item(tick_counts[i]));
	endtask

	task automatic test_saturation_ladder();
		// starts reach the top of the range; last segment drops back below
		send_item(load_item(0, 32'd0, 24'd1));
		send_item(load_item(1, 32'h8000_0000, 24'd1));
		send_item(load_item(2, PRICE_MAX, 24'd1));
		send_item(load_item(3, 32'h8000_0000, 24'd1));
		set_segment_count(4);
		send_item(price_item(32'h8000_0001));
		send_item(price_item(32'h7FFF_FFFF));
	endtask

	task automatic test_output_backpressure();
		no_gaps     = 1'b1;
		hold_cycles = 300;
		repeat (10)
			send_item(random_conversion(active_segments()));
		no_gaps = 1'b0;
	endtask

	task automatic build_ladder(input int r);
		logic [63:0] b;
		logic [23:0] t;
		case ($urandom_range(0, 2))
			0:       b = 64'd0;
			1:       b = 64'($urandom_range(0, 2_000_000));
			default: b = {32'd0, $urandom};
		endcase
		for (int k = 0; k < r; k++) begin
			t = random_tick();
			send_item(load_item(k, b[31:0], t));
			if ($urandom_range(0, 4) == 0)
				b = b + 64'($urandom);
			else
				b = b + 64'($urandom_range(0, 200)) * {40'd0, t}
					+ 64'($urandom_range(0, 32'(t) - 32'd1));
			b = b & SAT_LIMIT;
		end
	endtask

	task automatic test_random_ladders();
		int seq_no, n, r;
		logic [CFG_W-1:0] count_val;
		counting = 1'b1;
		seq_no   = 0;
		while (random_sent < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 5) == 0);
			case (seq_no)
				0: begin n = NUM_SEGS; count_val = 6'd63; end
				1: begin n = NUM_SEGS; count_val = 6'd32; end
				2: begin n = 1;        count_val = 6'd0;  end
				default: begin
					case ($urandom_range(0, 9))
						0:       n = NUM_SEGS;
						1, 2:    n = $urandom_range(9, NUM_SEGS - 1);
						default: n = $urandom_range(1, 8);
					endcase
					if (n == NUM_SEGS)
						count_val = CFG_W'($urandom_range(NUM_SEGS, 63));
					else if (n == 1)
						count_val = CFG_W'($urandom_range(0, 1));
					else
						count_val = CFG_W'(n);
				end
			endcase
			// once the first n entries are written, long ladders may reload only a few
			if (n > written_prefix() || n <= 8 || $urandom_range(0, 1) == 0)
				r = n;
			else
				r = $urandom_range(1, 8);
			build_ladder(r);
			set_segment_count(count_val);
			repeat ($urandom_range(8, 20))
				send_item(random_conversion(n));
			seq_no++;
		end
		no_gaps = 1'b0;
	endtask

	initial begin : stimulus
		for (int i = 0; i < NUM_SEGS; i++) begin
			ladder_base[i]  = '0;
			ladder_tick[i]  = '0;
			ladder_start[i] = '0;
		end
		seg_count_reg = 6'd1;
		seg_written   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_checks();
		test_rounding_and_range();
		test_saturation_ladder();
		test_output_backpressure();
		test_random_ladders();
		drain_pipeline();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("[tick_ladder_price_converter_core] OK");
		else
			$display("[tick_ladder_price_converter_core] ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/tlpc_pkg.sv
rtl/tlpc_div.sv
rtl/tlpc_datapath.sv
rtl/tlpc_ctrl.sv
rtl/tick_ladder_price_converter_core.sv
verif/tb_tick_ladder_price_converter_core.sv
